// ===== sv/mip_pkg.sv =====
// shared constants, types and microcode table of the modular inverse block
package mip_pkg;

   // widest supported code width, modulus up to 2^MAX_WIDTH
   localparam int unsigned MAX_WIDTH = 16;
   localparam int unsigned MUL_W     = 2 * MAX_WIDTH;
   localparam int unsigned WSAT_W    = $clog2(MAX_WIDTH + 1);

   // newton passes, each doubles the correct low bits starting from 3
   localparam int unsigned ITERS     = 5;
   localparam int unsigned ITER_W    = $clog2(ITERS);

   localparam int unsigned NUM_STEPS = 5;
   localparam int unsigned STEP_W    = $clog2(NUM_STEPS);

   typedef logic [MAX_WIDTH-1:0] word_type;
   typedef logic [STEP_W-1:0]    step_type;
   typedef logic [ITER_W-1:0]    iter_type;

   // datapath operations selected by a control word
   typedef enum logic [1:0] {
      OP_MUL_AX = 2'd0,   // p <= a * x
      OP_SUB2   = 2'd1,   // p <= 2 - p
      OP_MUL_XP = 2'd2,   // x <= x * p
      OP_FINISH = 2'd3    // emit result, p holds a * x
   } op_type;

   typedef struct packed {
      op_type   op;
      logic     loop_back;   // jump to target while passes remain
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic          active;
      ctrl_word_type word;
   } ctrl_type;

   // microprogram: three steps per newton pass, then the check product
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type cw;
      cw.op        = OP_FINISH;
      cw.loop_back = 1'b0;
      cw.target    = '0;
      unique case (step)
         step_type'(0): cw.op = OP_MUL_AX;
         step_type'(1): cw.op = OP_SUB2;
         step_type'(2): begin
            cw.op        = OP_MUL_XP;
            cw.loop_back = 1'b1;
            cw.target    = step_type'(0);
         end
         step_type'(3): cw.op = OP_MUL_AX;
         default:       cw.op = OP_FINISH;
      endcase
      return cw;
   endfunction

endpackage

// ===== sv/modular_inverse_pow2.sv =====
// top level: inverse of an operand modulo 2^w by microcoded newton iteration
// one item at a time: each result comes from five newton passes of three
//   microcode steps each, then the check product, through the single shared
//   16x16 multiplier, and no new item is taken before it is done
// busy is high from acceptance until the result strobe; results cannot stall
// reset (synchronous) idles the sequencer and sets code_width to 6
module modular_inverse_pow2 (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_operand,
   // result channel
   output logic        rsp_valid,
   output logic [15:0] rsp_inverse,
   output logic        rsp_has_inverse,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned W      = mip_pkg::MAX_WIDTH;
   localparam int unsigned WSAT_L = mip_pkg::WSAT_W;

   // configuration register, single word so every address maps to it
   logic [4:0] code_width_ff;

   // datapath registers
   mip_pkg::word_type a_ff, x_ff, p_ff, mask_ff;
   mip_pkg::word_type a_in, x_in, p_in, mask_in;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] inverse_ff,   inverse_in;
   logic        ok_ff,        ok_in;

   logic                 accept;
   mip_pkg::ctrl_type    ctrl;
   logic [WSAT_L-1:0]    wsat;
   mip_pkg::word_type    ones;
   mip_pkg::word_type    mul_l, mul_r, prod_lo;
   logic [mip_pkg::MUL_W-1:0] prod;
   logic [31:0]          x_wide;

   assign pready = 1'b1;
   assign prdata = {27'd0, code_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         code_width_ff <= 5'd6;
      end else if (psel && penable && pwrite) begin
         code_width_ff <= pwdata[4:0];
      end
   end

   // an item enters only while the sequencer is idle
   assign accept = start && !busy;
   assign busy   = ctrl.active;

   mip_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (accept),
      .ctrl  (ctrl)
   );

   // code width saturates at the datapath width; width zero gives an empty mask
   always_comb begin
      if (32'(code_width_ff) > W) begin
         wsat = WSAT_L'(W);
      end else begin
         wsat = WSAT_L'(code_width_ff);
      end
   end

   assign ones = '1;

   // one shared multiplier, operands picked by the current control word
   always_comb begin
      if (ctrl.word.op == mip_pkg::OP_MUL_XP) begin
         mul_l = x_ff;
         mul_r = p_ff;
      end else begin
         mul_l = a_ff;
         mul_r = x_ff;
      end
   end

   assign prod    = mip_pkg::MUL_W'(mul_l) * mip_pkg::MUL_W'(mul_r);
   assign prod_lo = prod[W-1:0] & mask_ff;

   // inverse field carries the low 16 bits of the datapath word
   assign x_wide = 32'(x_ff);

   always_comb begin
      a_in         = a_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      inverse_in   = inverse_ff;
      ok_in        = ok_ff;
      if (accept) begin
         // seed: for odd a, a itself is correct in its low 3 bits
         mask_in = ~(ones << wsat);
         a_in    = W'(req_operand) & ~(ones << wsat);
         x_in    = W'(req_operand) & ~(ones << wsat);
      end else if (ctrl.active) begin
         unique case (ctrl.word.op)
            mip_pkg::OP_MUL_AX: p_in = prod_lo;
            mip_pkg::OP_SUB2:   p_in = (W'(2) - p_ff) & mask_ff;
            mip_pkg::OP_MUL_XP: x_in = prod_lo;
            mip_pkg::OP_FINISH: begin
               // even operand or empty modulus never yields a product of one
               rsp_valid_in = 1'b1;
               ok_in        = (p_ff == W'(1));
               inverse_in   = (p_ff == W'(1)) ? x_wide[15:0] : 16'd0;
            end
            default: p_in = p_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      x_ff       <= x_in;
      p_ff       <= p_in;
      mask_ff    <= mask_in;
      inverse_ff <= inverse_in;
      ok_ff      <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inverse     = inverse_ff;
   assign rsp_has_inverse = ok_ff;

endmodule

// ===== sv/mip_seq.sv =====
// microcode sequencer: step counter, pass counter and control rom
module mip_seq (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   output mip_pkg::ctrl_type ctrl
);

   logic               run_ff,  run_in;
   mip_pkg::step_type  step_ff, step_in;
   mip_pkg::iter_type  iter_ff, iter_in;
   mip_pkg::ctrl_word_type cw;

   assign cw = mip_pkg::ucode(step_ff);

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      iter_in = iter_ff;
      if (go) begin
         run_in  = 1'b1;
         step_in = '0;
         iter_in = '0;
      end else if (run_ff) begin
         priority if (cw.op == mip_pkg::OP_FINISH) begin
            run_in = 1'b0;
         end else if (cw.loop_back &&
                      iter_ff != mip_pkg::iter_type'(mip_pkg::ITERS - 1)) begin
            step_in = cw.target;
            iter_in = iter_ff + 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
         iter_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         iter_ff <= iter_in;
      end
   end

   assign ctrl.active = run_ff;
   assign ctrl.word   = cw;

endmodule

// ===== tb/sv/inverse_checker.sv =====
// checker for the modular inverse block: watches channels and csr port, predicts, compares
`timescale 1ns / 1ps
module inverse_checker #(
   parameter logic [1:0] CODE_WIDTH_ADDR = 2'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_operand,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_inverse,
   input  logic        rsp_has_inverse,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          pending,
   output int          fail_count
);

   localparam logic [4:0] RESET_CODE_WIDTH = 5'd6;

   typedef struct packed {
      logic [15:0] inverse;
      logic        has_inverse;
   } inverse_result_type;

   inverse_result_type expected_inverses[$];
   logic [4:0]         code_width = RESET_CODE_WIDTH;
   int                 n_fail     = 0;

   // hensel lifting: fix one bit of the inverse per pass
   function automatic inverse_result_type predict_inverse(input logic [4:0]  cw,
                                                          input logic [15:0] operand);
      inverse_result_type r;
      int unsigned        w;
      logic [63:0]        mask;
      logic [63:0]        a;
      logic [63:0]        x;
      logic [63:0]        prod;
      r = '0;
      w = (cw > mip_pkg::MAX_WIDTH) ? mip_pkg::MAX_WIDTH : cw;
      if (w == 0 || !operand[0])
         return r;
      mask = (64'd1 << w) - 64'd1;
      a    = {48'd0, operand} & mask;
      x    = 64'd1;
      for (int i = 1; i < w; i++) begin
         prod = a * x;
         if (prod[i])
            x[i] = 1'b1;
      end
      prod = (a * x) & mask;
      if (prod == 64'd1) begin
         r.inverse     = x[15:0];
         r.has_inverse = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      inverse_result_type want;
      if (reset) begin
         expected_inverses.delete();
         code_width = RESET_CODE_WIDTH;
      end else begin
         if (rsp_valid) begin
            if (expected_inverses.size() == 0) begin
               $error("unexpected result: inverse %0h has_inverse %0b",
                      rsp_inverse, rsp_has_inverse);
               n_fail++;
            end else begin
               want = expected_inverses.pop_front();
               if (rsp_inverse !== want.inverse) begin
                  $error("inverse: expected %0h, got %0h", want.inverse, rsp_inverse);
                  n_fail++;
               end
               if (rsp_has_inverse !== want.has_inverse) begin
                  $error("has_inverse: expected %0b, got %0b",
                         want.has_inverse, rsp_has_inverse);
                  n_fail++;
               end
            end
         end
         if (start && !busy)
            expected_inverses = {expected_inverses,
                                 predict_inverse(code_width, req_operand)};
         if (psel && penable && pready && paddr == CODE_WIDTH_ADDR) begin
            if (pwrite) begin
               code_width = pwdata[4:0];
            end else if (prdata !== {27'd0, code_width}) begin
               $error("code_width: expected %0d, got %0d", code_width, prdata);
               n_fail++;
            end
         end
      end
      pending    <= expected_inverses.size();
      fail_count <= n_fail;
   end

endmodule

// ===== tb/sv/tb_modular_inverse_pow2.sv =====
// testbench top for the modular inverse block: stimulus, csr phases and verdict
`timescale 1ns / 1ps
module tb_modular_inverse_pow2;

   // csr map: code_width is the only register
   localparam logic [1:0] CODE_WIDTH_ADDR = 2'd0;
   // items per code width setting, first setting also gets the corner list
   localparam int ITEMS_PER_PHASE = 55;
   // reset value plus eight fixed settings plus two random ones
   localparam int NUM_PHASES      = 11;
   // idle window after the last phase so that stray results can show
   localparam int DRAIN_CYCLES    = 40;
   // watchdog limit, the slowest legal run taken several times over
   localparam int CYCLE_LIMIT     = 300000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_operand;
   logic        rsp_valid;
   logic [15:0] rsp_inverse;
   logic        rsp_has_inverse;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          pending;
   int          fail_count;
   int          cycle_count = 0;
   int          n_items     = 0;
   int          n_odd       = 0;
   // code width used to shape operands, mirrors the csr
   logic [4:0]  cur_width   = 5'd6;

   // fixed settings: minimal, full, zero, all ones, just above the cap, ...
   logic [4:0]  width_plan [8]       = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15};
   // corners at the reset width (w = 6): zero, one, evens, modulus edges, wide values
   logic [15:0] corner_operands [16] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                         16'h003F, 16'h0040, 16'h0041, 16'h007F,
                                         16'h8000, 16'h8001, 16'hFFFE, 16'hFFFF,
                                         16'h5555, 16'hAAAA, 16'h0005, 16'h0021};

   modular_inverse_pow2 i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_inverse     (rsp_inverse),
      .rsp_has_inverse (rsp_has_inverse),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   inverse_checker #(.CODE_WIDTH_ADDR(CODE_WIDTH_ADDR)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_inverse     (rsp_inverse),
      .rsp_has_inverse (rsp_has_inverse),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .pending         (pending),
      .fail_count      (fail_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // operand mix: mostly odd, some folded below the modulus, evens and edges
   function automatic logic [15:0] pick_operand(input logic [4:0] cw);
      logic [15:0] v;
      logic [15:0] mask;
      int unsigned w;
      int unsigned mode;
      v    = 16'($urandom);
      w    = (cw > 5'd16) ? 16 : cw;
      mask = 16'((32'd1 << w) - 32'd1);
      mode = $urandom_range(0, 9);
      case (mode)
         0, 1, 2, 3, 4: v[0] = 1'b1;
         5, 6: begin
            v    = v & mask;
            v[0] = 1'b1;
         end
         7:       v = v & mask;
         8:       v[0] = 1'b0;
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 16'h0000;
               1:       v = 16'h0001;
               2:       v = mask;
               3:       v = 16'hFFFF;
               default: v = 16'((32'd1 << w) + 32'd1);
            endcase
         end
      endcase
      return v;
   endfunction

   // hold start high until the item is taken; start stays high for back-to-back items
   task automatic issue_operand(input logic [15:0] value);
      start       <= 1'b1;
      req_operand <= value;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      n_items++;
      if (value[0])
         n_odd++;
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // pause until every result outstanding has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // one apb transfer, setup then access, then psel and penable drop back to idle
   task automatic csr_access(input logic is_write, input logic [4:0] value);
      logic [26:0] junk;
      junk    = 27'($urandom);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CODE_WIDTH_ADDR;
      pwdata  <= {junk, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          sent;
      int          burst;
      logic [4:0]  next_width;
      // every input known from time zero
      reset       = 1'b1;
      start       = 1'b0;
      req_operand = 16'd0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = CODE_WIDTH_ADDR;
      pwdata      = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value readback
      csr_access(1'b0, 5'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            // block is idle here: all results in, start low
            next_width = (p <= 8) ? width_plan[p-1] : 5'($urandom_range(0, 31));
            csr_access(1'b1, next_width);
            csr_access(1'b0, 5'd0);
            cur_width = next_width;
         end else begin
            // directed corners back to back at the reset width
            foreach (corner_operands[i])
               issue_operand(corner_operands[i]);
            idle_cycles(3);
         end

         // random bursts with random gaps, sometimes streaming straight on
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               issue_operand(pick_operand(cur_width));
               sent++;
            end
            case ($urandom_range(0, 9))
               0, 1, 2: ;                                  // no gap
               3:       wait_drained();                     // full drain
               default: idle_cycles($urandom_range(1, 40)); // gap of any phase
            endcase
         end
         wait_drained();
      end

      // catch stray results after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d operands (%0d odd) over %0d code width settings",
               n_items, n_odd, NUM_PHASES);
      $display("settings included widths 0, 1, 16, 31 and saturating values, each read back");
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
